@@ rtl/core/unn_pkg.sv @@
package unn_pkg;

  // input and result items
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_name;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       last_of_name;
  } out_item_t;

  // one decoded code point, already encoded, first byte in the top lane
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic        present;
    logic        last;
  } cp_entry_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CP_W = 21;

  // fullwidth block folded onto ascii
  localparam logic [CP_W-1:0] FW_LO     = 21'h00ff01;
  localparam logic [CP_W-1:0] FW_HI     = 21'h00ff5e;
  localparam logic [CP_W-1:0] FW_OFFSET = 21'h00fee0;

  // cjk punctuation and the fullwidth slash, which are dropped
  localparam logic [CP_W-1:0] CJK_SPACE   = 21'h003000;
  localparam logic [CP_W-1:0] CJK_MIDDOT  = 21'h0030fb;
  localparam logic [CP_W-1:0] CJK_COMMA   = 21'h003001;
  localparam logic [CP_W-1:0] CJK_STOP    = 21'h003002;
  localparam logic [CP_W-1:0] CJK_LBRACK  = 21'h003010;
  localparam logic [CP_W-1:0] CJK_RBRACK  = 21'h003011;
  localparam logic [CP_W-1:0] CJK_LQUOTE  = 21'h00300c;
  localparam logic [CP_W-1:0] CJK_RQUOTE  = 21'h00300d;
  localparam logic [CP_W-1:0] FW_SLASH    = 21'h00ff0f;

endpackage

@@ rtl/core/utf8_name_normalizer.sv @@
// path: the first output byte passes the entry queue, current-entry and output registers
// throughput: one input byte per cycle; output one byte per cycle while out_stall is low,
// set by the single output register; multi-byte points fill the entry queue and stall input
// reset: synchronous active-low rst_n clears decoder state, queue and output
// valid; no clearing pass
module utf8_name_normalizer #(
  parameter int QUEUE_DEPTH = unn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  unn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output unn_pkg::out_item_t out_data
);

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  unn_pkg::cp_entry_t q_entry;
  unn_pkg::cp_entry_t q_head;

  assign in_stall = q_full;

  // decode, fold, filter, encode
  unn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // entry queue between front and back
  unn_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // byte serializer and output register
  unn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/unn_front.sv @@
module unn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  unn_pkg::in_item_t   in_data,
  input  logic                q_full,
  output logic                q_push,
  output unn_pkg::cp_entry_t  q_entry
);

  logic [unn_pkg::CP_W-1:0] part_r, part_nxt;
  logic [1:0]               exp_r, exp_nxt;

  logic                     in_accept;
  logic [7:0]               b;
  logic                     consumed;
  logic [unn_pkg::CP_W-1:0] gathered;
  logic                     have_cp;
  logic [unn_pkg::CP_W-1:0] cp_raw;
  logic [unn_pkg::CP_W-1:0] cp_fw;
  logic [unn_pkg::CP_W-1:0] cp;
  logic                     kept;
  logic [31:0]              enc;
  logic [2:0]               enc_cnt;

  assign b         = in_data.in_byte;
  assign in_accept = in_valid && !q_full;
  assign gathered  = {part_r[unn_pkg::CP_W-7:0], b[5:0]};

  // decode: continuation, abort, lead byte
  always_comb begin
    consumed = (exp_r != 2'd0) && (b[7:6] == 2'b10);
    have_cp  = 1'b0;
    cp_raw   = '0;
    part_nxt = '0;
    exp_nxt  = 2'd0;
    if (consumed) begin
      part_nxt = gathered;
      exp_nxt  = exp_r - 2'd1;
      if (exp_r == 2'd1) begin
        have_cp  = 1'b1;
        cp_raw   = gathered;
        part_nxt = '0;
      end
    end else begin
      if (b[7] == 1'b0) begin
        have_cp = 1'b1;
        cp_raw  = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        part_nxt = {16'd0, b[4:0]};
        exp_nxt  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_nxt = {17'd0, b[3:0]};
        exp_nxt  = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part_nxt = {18'd0, b[2:0]};
        exp_nxt  = 2'd3;
      end
    end
    if (in_data.end_of_name) begin
      part_nxt = '0;
      exp_nxt  = 2'd0;
    end
  end

  // fold fullwidth and upper case, then filter
  always_comb begin
    cp_fw = cp_raw;
    if (cp_raw >= unn_pkg::FW_LO && cp_raw <= unn_pkg::FW_HI) begin
      cp_fw = cp_raw - unn_pkg::FW_OFFSET;
    end
    cp = cp_fw;
    if (cp_fw inside {[21'h41 : 21'h5a]}) begin
      cp = cp_fw + 21'h20;
    end
    if (cp inside {[21'h61 : 21'h7a], [21'h30 : 21'h39]}) begin
      kept = 1'b1;
    end else if (cp <= 21'h7f) begin
      kept = 1'b0;
    end else if (cp inside {unn_pkg::CJK_SPACE, unn_pkg::CJK_MIDDOT, unn_pkg::CJK_COMMA,
                            unn_pkg::CJK_STOP, unn_pkg::CJK_LBRACK, unn_pkg::CJK_RBRACK,
                            unn_pkg::CJK_LQUOTE, unn_pkg::CJK_RQUOTE,
                            unn_pkg::FW_SLASH}) begin
      kept = 1'b0;
    end else begin
      kept = 1'b1;
    end
  end

  // utf-8 encode, first byte in the top lane
  always_comb begin
    if (cp <= 21'h7f) begin
      enc     = {cp[7:0], 24'd0};
      enc_cnt = 3'd1;
    end else if (cp <= 21'h7ff) begin
      enc     = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
      enc_cnt = 3'd2;
    end else if (cp <= 21'hffff) begin
      enc     = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
      enc_cnt = 3'd3;
    end else begin
      enc     = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
      enc_cnt = 3'd4;
    end
  end

  // queue entry: encoded point, or bare end marker
  always_comb begin
    q_entry.last = in_data.end_of_name;
    if (have_cp && kept) begin
      q_entry.bytes   = enc;
      q_entry.cnt     = enc_cnt;
      q_entry.present = 1'b1;
    end else begin
      q_entry.bytes   = '0;
      q_entry.cnt     = 3'd1;
      q_entry.present = 1'b0;
    end
    q_push = in_accept && ((have_cp && kept) || in_data.end_of_name);
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      exp_r  <= 2'd0;
    end else if (in_accept) begin
      part_r <= part_nxt;
      exp_r  <= exp_nxt;
    end
  end

endmodule

@@ rtl/core/unn_fifo.sv @@
module unn_fifo #(
  parameter int DEPTH = unn_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  unn_pkg::cp_entry_t  push_entry,
  input  logic                pop,
  output unn_pkg::cp_entry_t  head,
  output logic                full,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  unn_pkg::cp_entry_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/core/unn_back.sv @@
module unn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  unn_pkg::cp_entry_t  head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output unn_pkg::out_item_t  out_data
);

  logic [31:0]        cur_bytes_r, cur_bytes_nxt;
  logic [2:0]         cur_cnt_r, cur_cnt_nxt;
  logic               cur_present_r, cur_present_nxt;
  logic               cur_last_r, cur_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  unn_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_load;

  assign out_load  = !out_valid_r || !out_stall;
  assign q_pop     = !q_empty && ((cur_cnt_r == 3'd0) || (out_load && cur_cnt_r == 3'd1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // serialize current entry into the output register
  always_comb begin
    cur_bytes_nxt   = cur_bytes_r;
    cur_cnt_nxt     = cur_cnt_r;
    cur_present_nxt = cur_present_r;
    cur_last_nxt    = cur_last_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b0;
      if (cur_cnt_r != 3'd0) begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.out_byte     = cur_bytes_r[31:24];
        out_data_nxt.byte_present = cur_present_r;
        out_data_nxt.last_of_name = cur_last_r && (cur_cnt_r == 3'd1);
        cur_bytes_nxt             = {cur_bytes_r[23:0], 8'd0};
        cur_cnt_nxt               = cur_cnt_r - 3'd1;
      end
    end
    if (q_pop) begin
      cur_bytes_nxt   = head.bytes;
      cur_cnt_nxt     = head.cnt;
      cur_present_nxt = head.present;
      cur_last_nxt    = head.last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r   <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_cnt_r   <= cur_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur_bytes_r   <= cur_bytes_nxt;
    cur_present_r <= cur_present_nxt;
    cur_last_r    <= cur_last_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

@@ tb/unn_checker.sv @@
module unn_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  unn_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  unn_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 bytes_awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // decoder state mirrored from the block, and the queue of expected bytes
  logic [unn_pkg::CP_W-1:0] cp_acc;
  logic [1:0]               cont_left;
  unn_pkg::out_item_t       norm_bytes[$];

  // fullwidth to ascii, then upper to lower case
  function automatic logic [unn_pkg::CP_W-1:0] fold_cp(input logic [unn_pkg::CP_W-1:0] cp);
    logic [unn_pkg::CP_W-1:0] f;
    f = cp;
    if (f >= unn_pkg::FW_LO && f <= unn_pkg::FW_HI) f = f - unn_pkg::FW_OFFSET;
    if (f >= 21'h41 && f <= 21'h5a) f = f + 21'h20;
    return f;
  endfunction

  function automatic bit is_kept(input logic [unn_pkg::CP_W-1:0] cp);
    if ((cp >= 21'h61 && cp <= 21'h7a) || (cp >= 21'h30 && cp <= 21'h39)) return 1'b1;
    if (cp <= 21'h7f) return 1'b0;
    case (cp)
      unn_pkg::CJK_SPACE, unn_pkg::CJK_MIDDOT, unn_pkg::CJK_COMMA, unn_pkg::CJK_STOP,
      unn_pkg::CJK_LBRACK, unn_pkg::CJK_RBRACK, unn_pkg::CJK_LQUOTE,
      unn_pkg::CJK_RQUOTE, unn_pkg::FW_SLASH: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  // folded and filtered utf-8 bytes, first byte in the top lane
  function automatic int encode_cp(input logic [unn_pkg::CP_W-1:0] raw,
                                   output logic [31:0] enc);
    logic [unn_pkg::CP_W-1:0] cp;
    cp  = fold_cp(raw);
    enc = '0;
    if (!is_kept(cp)) return 0;
    if (cp <= 21'h7f) begin
      enc[31:24] = cp[7:0];
      return 1;
    end
    if (cp <= 21'h7ff) begin
      enc[31:16] = {3'b110, cp[10:6], 2'b10, cp[5:0]};
      return 2;
    end
    if (cp <= 21'hffff) begin
      enc[31:8] = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      return 3;
    end
    enc = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    return 4;
  endfunction

  // decode one input byte and queue the bytes it yields
  task automatic predict_byte(input unn_pkg::in_item_t it);
    logic [7:0]         b;
    logic [31:0]        enc;
    int                 n;
    int                 k;
    bit                 taken;
    unn_pkg::out_item_t r;
    b     = it.in_byte;
    n     = 0;
    taken = 1'b0;
    enc   = '0;
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[unn_pkg::CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) begin
          n      = encode_cp(cp_acc, enc);
          cp_acc = '0;
        end
        taken = 1'b1;
      end else begin
        // bad continuation drops the pending sequence
        cont_left = '0;
        cp_acc    = '0;
      end
    end
    if (!taken) begin
      if (b[7] == 1'b0) begin
        n = encode_cp({13'b0, b}, enc);
      end else if (b[7:5] == 3'b110) begin
        cp_acc    = {16'b0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc    = {17'b0, b[3:0]};
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc    = {18'b0, b[2:0]};
        cont_left = 2'd3;
      end
    end
    if (it.end_of_name) begin
      cp_acc    = '0;
      cont_left = '0;
    end
    for (k = 0; k < n; k++) begin
      r.out_byte     = enc[31-8*k -: 8];
      r.byte_present = 1'b1;
      r.last_of_name = it.end_of_name && (k == n - 1);
      norm_bytes     = {norm_bytes, r};
    end
    // bare end marker
    if (it.end_of_name && n == 0) begin
      r              = '0;
      r.last_of_name = 1'b1;
      norm_bytes     = {norm_bytes, r};
    end
  endtask

  // watch both channels at each edge
  always @(posedge clk) begin : watch
    unn_pkg::out_item_t want;
    if (!rst_n) begin
      cp_acc    = '0;
      cont_left = '0;
      norm_bytes.delete();
    end else begin
      if (in_valid && !in_stall) predict_byte(in_data);
      if (out_valid && !out_stall) begin
        if (norm_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %0h byte_present %0b last_of_name %0b",
                 out_data.out_byte, out_data.byte_present, out_data.last_of_name);
          mismatch_count++;
        end else begin
          want = norm_bytes.pop_front();
          if (want.out_byte != out_data.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
            mismatch_count++;
          end
          if (want.byte_present != out_data.byte_present) begin
            $error("byte_present: expected %0b, got %0b",
                   want.byte_present, out_data.byte_present);
            mismatch_count++;
          end
          if (want.last_of_name != out_data.last_of_name) begin
            $error("last_of_name: expected %0b, got %0b",
                   want.last_of_name, out_data.last_of_name);
            mismatch_count++;
          end
        end
      end
    end
    bytes_awaited = norm_bytes.size();
  end

endmodule

@@ tb/tb_utf8_name_normalizer.sv @@
module tb_utf8_name_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_BYTES  = 180;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 60;
  localparam int HOLD_CYCLES = 250;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  unn_pkg::in_item_t  in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  unn_pkg::out_item_t out_data;

  int        mismatch_count;
  int        bytes_awaited;
  int        cycle_count = 0;
  int        items_sent  = 0;
  bit        steady_in   = 1'b0;
  logic [7:0] name_bytes[$];

  logic [unn_pkg::CP_W-1:0] cjk_marks[9] = '{unn_pkg::CJK_SPACE, unn_pkg::CJK_MIDDOT,
                                             unn_pkg::CJK_COMMA, unn_pkg::CJK_STOP,
                                             unn_pkg::CJK_LBRACK, unn_pkg::CJK_RBRACK,
                                             unn_pkg::CJK_LQUOTE, unn_pkg::CJK_RQUOTE,
                                             unn_pkg::FW_SLASH};

  utf8_name_normalizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  unn_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .bytes_awaited (bytes_awaited)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_utf8_name_normalizer: errors");
      $finish;
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // raw utf-8 encoding of len bytes, overlong allowed, first keep bytes queued
  task automatic add_code_point(input logic [20:0] cp, input int len, input int keep);
    logic [31:0] enc;
    int          k;
    case (len)
      1: enc = {1'b0, cp[6:0], 24'b0};
      2: enc = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'b0};
      3: enc = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'b0};
      default: enc = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                      2'b10, cp[5:0]};
    endcase
    for (k = 0; k < keep; k++) name_bytes = {name_bytes, enc[31-8*k -: 8]};
  endtask

  // one random piece of a name, mostly well formed
  task automatic add_random_piece();
    int r;
    int s;
    int len;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      add_code_point(21'($urandom_range(0, 127)), 1, 1);
    end else if (r < 35) begin
      s = $urandom_range(0, 2);
      if (s == 0) add_code_point(21'($urandom_range(8'h41, 8'h5a)), 1, 1);
      else if (s == 1) add_code_point(21'($urandom_range(8'h30, 8'h39)), 1, 1);
      else add_code_point(21'($urandom_range(8'h61, 8'h7a)), 1, 1);
    end else if (r < 50) begin
      add_code_point(21'($urandom_range(0, 12'h7ff)), 2, 2);
    end else if (r < 68) begin
      s = $urandom_range(0, 2);
      if (s == 0) add_code_point(21'($urandom_range(unn_pkg::FW_LO, unn_pkg::FW_HI)), 3, 3);
      else if (s == 1) add_code_point(cjk_marks[$urandom_range(0, 8)], 3, 3);
      else add_code_point(21'($urandom_range(0, 17'hffff)), 3, 3);
    end else if (r < 78) begin
      add_code_point(21'($urandom_range(0, 21'h1fffff)), 4, 4);
    end else if (r < 85) begin
      // stray byte
      if ($urandom_range(0, 1) == 0) name_bytes = {name_bytes, 8'($urandom_range(8'h80, 8'hbf))};
      else name_bytes = {name_bytes, 8'($urandom_range(8'hf8, 8'hff))};
    end else if (r < 94) begin
      // sequence broken off before its last continuation
      len = $urandom_range(2, 4);
      add_code_point(21'($urandom_range(0, 21'h1fffff)), len, $urandom_range(1, len - 1));
    end else begin
      name_bytes = {name_bytes, 8'($urandom_range(0, 255))};
    end
  endtask

  // offer one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    unn_pkg::in_item_t it;
    gap = (steady_in || $urandom_range(0, 99) < 55) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.in_byte     = b;
    it.end_of_name = last;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_name();
    int i;
    steady_in = ($urandom_range(0, 4) == 0);
    for (i = 0; i < name_bytes.size(); i++) begin
      send_byte(name_bytes[i], i == name_bytes.size() - 1);
    end
  endtask

  // receiver stalls, one long hold-off while the sender keeps going
  initial begin : receiver
    int  stall_left;
    int  hold_left;
    int  phase_left;
    bit  held;
    bit  quiet;
    stall_left = 0;
    hold_left  = 0;
    phase_left = 0;
    held       = 1'b0;
    quiet      = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        quiet      = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 200);
      end else begin
        phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && items_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pause_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int pieces;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // letters, digits, code point zero, delete char, marker with no byte
    name_bytes = '{8'h41, 8'h5a, 8'h30, 8'h39, 8'h00, 8'h7f};
    send_name();
    // fullwidth capital a, fullwidth slash, ideographic space, stray bytes
    name_bytes = '{8'hef, 8'hbc, 8'ha1, 8'hef, 8'hbc, 8'h8f, 8'he3, 8'h80, 8'h80,
                   8'h80, 8'hff};
    send_name();
    // bad continuation, four byte point, sequence cut short at the end
    name_bytes = '{8'hc3, 8'h41, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'he3, 8'h81};
    send_name();
    // lead byte arriving as the last byte
    name_bytes = '{8'hc3};
    send_name();

    // random names
    while (items_sent < NAME_BYTES) begin
      name_bytes.delete();
      pieces = $urandom_range(1, 6);
      repeat (pieces) add_random_piece();
      send_name();
    end
    in_valid <= 1'b0;

    // let the checker see the last transfer before waiting on it
    repeat (2) @(posedge clk);
    while (bytes_awaited != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && bytes_awaited == 0) begin
      $display("tb_utf8_name_normalizer: clean");
    end else begin
      $display("tb_utf8_name_normalizer: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/unn_pkg.sv
rtl/core/unn_front.sv
rtl/core/unn_fifo.sv
rtl/core/unn_back.sv
rtl/core/utf8_name_normalizer.sv
tb/unn_checker.sv
tb/tb_utf8_name_normalizer.sv
